// File: src/ffba_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ffba_pkg;

  // map geometry
  localparam int MAP_ROWS  = 16;
  localparam int MAP_COLS  = 64;
  localparam int MAP_DEPTH = MAP_ROWS * MAP_COLS;

  // field widths
  localparam int OP_W   = 1;
  localparam int SIZE_W = 11;
  localparam int OWN_W  = 5;
  localparam int BLK_W  = 10;
  localparam int ST_W   = 2;
  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;

  // linear length and sums of start and size
  localparam int LEN_W = BLK_W + 1;
  localparam int SUM_W = LEN_W + 1;

  // map memory: one word holds a group of blocks
  localparam int LANES   = 8;
  localparam int LANE_W  = $clog2(LANES);
  localparam int WORDS   = MAP_DEPTH / LANES;
  localparam int WADDR_W = $clog2(WORDS);
  localparam int WORD_W  = LANES * OWN_W;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = COL_W;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS = 1'b1;
  localparam logic [ROW_W-1:0] ROWS_RESET = ROW_W'(MAP_ROWS);
  localparam logic [COL_W-1:0] COLS_RESET = COL_W'(MAP_COLS);

  // codes
  localparam logic [OWN_W-1:0] FREE_CODE = 5'd31;
  localparam logic [OP_W-1:0]  OP_ALLOC  = 1'b0;
  localparam logic [OP_W-1:0]  OP_FREE   = 1'b1;
  localparam logic [ST_W-1:0]  ST_DONE    = 2'd0;
  localparam logic [ST_W-1:0]  ST_NO_ROOM = 2'd1;
  localparam logic [ST_W-1:0]  ST_CLIPPED = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic clear;
    logic take;
    logic prep;
    logic scan;
    logic wprep;
    logic write;
    logic put;
  } ffba_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_last;
    logic is_free;
    logic alloc_ok;
    logic free_go;
    logic hit;
    logic scan_last;
    logic write_last;
    logic out_free;
  } ffba_stat_t;

endpackage
`default_nettype wire

// File: src/ffba_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module ffba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: src/ffba_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module ffba_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [ffba_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ffba_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic [ffba_pkg::OP_W-1:0]       operation,
  input  logic [ffba_pkg::SIZE_W-1:0]     request_size,
  input  logic [ffba_pkg::OWN_W-1:0]      owner_id,
  input  logic [ffba_pkg::BLK_W-1:0]      free_start,
  input  ffba_pkg::ffba_cmd_t             cmd,
  output ffba_pkg::ffba_stat_t            stat,
  input  logic                            out_stall,
  output logic                            out_valid,
  output logic [ffba_pkg::ST_W-1:0]       status,
  output logic [ffba_pkg::BLK_W-1:0]      allocated_start
);
  import ffba_pkg::*;

  logic [ROW_W-1:0]   rows_q;
  logic [COL_W-1:0]   cols_q;
  logic [ROW_W-1:0]   rows_c;
  logic [COL_W-1:0]   cols_c;
  logic [LEN_W-1:0]   len_q;
  logic [LEN_W-1:0]   len_m1;

  logic [OP_W-1:0]    op_q;
  logic [SIZE_W-1:0]  size_q;
  logic [OWN_W-1:0]   owner_q;
  logic [BLK_W-1:0]   start_q;

  logic [WADDR_W-1:0] rptr;
  logic [WADDR_W-1:0] dptr;
  logic [WADDR_W-1:0] clr_cnt;
  logic [SIZE_W-1:0]  run_q;
  logic [BLK_W-1:0]   wr_lo;
  logic [BLK_W-1:0]   wr_hi;
  logic [ST_W-1:0]    res_status;
  logic [BLK_W-1:0]   res_start;

  logic               size_nz;
  logic [SUM_W-1:0]   free_end_x;
  logic               clip;
  logic [BLK_W-1:0]   free_hi;
  logic [SUM_W-1:0]   free_last_x;

  logic [SIZE_W-1:0]  run_c;
  logic               hit_c;
  logic [BLK_W-1:0]   hit_start_c;
  logic [BLK_W-1:0]   hit_idx_c;
  logic [BLK_W-1:0]   scan_idx;
  logic [LEN_W-1:0]   place_x;

  logic [BLK_W-1:0]   mrg_idx;
  logic [OWN_W-1:0]   fill;
  logic [WORD_W-1:0]  merged;
  logic [WORD_W-1:0]  rdata;
  logic               ram_we;
  logic [WADDR_W-1:0] ram_waddr;
  logic [WORD_W-1:0]  ram_wdata;
  logic               advance;

  // clamp the dimensions and form the line length
  always_comb begin
    rows_c = rows_q;
    if (rows_q == '0) begin
      rows_c = ROW_W'(1);
    end else if (rows_q > ROW_W'(MAP_ROWS)) begin
      rows_c = ROW_W'(MAP_ROWS);
    end
    cols_c = cols_q;
    if (cols_q == '0) begin
      cols_c = COL_W'(1);
    end else if (cols_q > COL_W'(MAP_COLS)) begin
      cols_c = COL_W'(MAP_COLS);
    end
  end

  assign len_m1 = len_q - LEN_W'(1);

  // free range planning
  assign size_nz     = size_q != '0;
  assign free_end_x  = SUM_W'(start_q) + SUM_W'(size_q);
  assign clip        = size_nz && (free_end_x > SUM_W'(len_q));
  assign free_last_x = free_end_x - SUM_W'(1);
  assign free_hi     = clip ? len_m1[BLK_W-1:0] : free_last_x[BLK_W-1:0];

  // run search over the word in the read register
  always_comb begin
    run_c       = run_q;
    hit_c       = 1'b0;
    hit_start_c = '0;
    hit_idx_c   = '0;
    scan_idx    = '0;
    place_x     = '0;
    for (int k = 0; k < LANES; k++) begin
      scan_idx = {dptr, LANE_W'(k)};
      if ((LEN_W'(scan_idx) < len_q) && (rdata[k*OWN_W +: OWN_W] == FREE_CODE)) begin
        run_c = run_c + SIZE_W'(1);
      end else begin
        run_c = '0;
      end
      if (!hit_c && (run_c == size_q)) begin
        hit_c       = 1'b1;
        place_x     = LEN_W'(scan_idx) + LEN_W'(1) - LEN_W'(size_q);
        hit_start_c = place_x[BLK_W-1:0];
        hit_idx_c   = scan_idx;
      end
    end
  end

  // merge the fill code into the blocks of the run
  assign fill = (op_q == OP_ALLOC) ? owner_q : FREE_CODE;

  always_comb begin
    merged  = rdata;
    mrg_idx = '0;
    for (int k = 0; k < LANES; k++) begin
      mrg_idx = {dptr, LANE_W'(k)};
      if ((mrg_idx >= wr_lo) && (mrg_idx <= wr_hi)) begin
        merged[k*OWN_W +: OWN_W] = fill;
      end
    end
  end

  // map memory
  assign ram_we    = cmd.clear | cmd.write;
  assign ram_waddr = cmd.clear ? clr_cnt : dptr;
  assign ram_wdata = cmd.clear ? {LANES{FREE_CODE}} : merged;

  ffba_ram #(
    .WIDTH(WORD_W),
    .DEPTH(WORDS)
  ) u_map (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(rptr),
    .rdata(rdata)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rows_q    <= ROWS_RESET;
      cols_q    <= COLS_RESET;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_ROWS: rows_q <= cfg_data[ROW_W-1:0];
          CFG_COLS: cols_q <= cfg_data[COL_W-1:0];
          default: ;
        endcase
      end
      if (cmd.clear) begin
        clr_cnt <= clr_cnt + WADDR_W'(1);
      end
      if (cmd.put) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign advance = cmd.prep | cmd.wprep | cmd.write | (cmd.scan & ~hit_c);

  // item and pointer registers
  always_ff @(posedge clk) begin
    len_q <= LEN_W'(rows_c) * LEN_W'(cols_c);
    if (cmd.take) begin
      op_q    <= operation;
      size_q  <= request_size;
      owner_q <= owner_id;
      start_q <= free_start;
      rptr    <= (operation == OP_FREE) ? free_start[BLK_W-1:LANE_W] : '0;
    end
    if (advance) begin
      dptr <= rptr;
      rptr <= rptr + WADDR_W'(1);
    end
    if (cmd.prep) begin
      run_q     <= '0;
      res_start <= '0;
      wr_lo     <= start_q;
      wr_hi     <= free_hi;
      if (op_q == OP_ALLOC) begin
        res_status <= ST_NO_ROOM;
      end else begin
        res_status <= clip ? ST_CLIPPED : ST_DONE;
      end
    end
    if (cmd.scan) begin
      run_q <= run_c;
      if (hit_c) begin
        res_status <= ST_DONE;
        res_start  <= hit_start_c;
        wr_lo      <= hit_start_c;
        wr_hi      <= hit_idx_c;
        rptr       <= hit_start_c[BLK_W-1:LANE_W];
      end
    end
    if (cmd.put) begin
      status          <= res_status;
      allocated_start <= res_start;
    end
  end

  // status toward the controller
  assign stat.clear_last = clr_cnt == WADDR_W'(WORDS - 1);
  assign stat.is_free    = op_q == OP_FREE;
  assign stat.alloc_ok   = size_nz && (LEN_W'(size_q) <= len_q);
  assign stat.free_go    = size_nz && (LEN_W'(start_q) < len_q);
  assign stat.hit        = hit_c;
  assign stat.scan_last  = dptr == len_m1[BLK_W-1:LANE_W];
  assign stat.write_last = dptr == wr_hi[BLK_W-1:LANE_W];
  assign stat.out_free   = !out_valid || !out_stall;

endmodule
`default_nettype wire

// File: src/ffba_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module ffba_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  output ffba_pkg::ffba_cmd_t  cmd,
  input  ffba_pkg::ffba_stat_t stat
);
  import ffba_pkg::*;

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_SETUP = 7'b0000100,
    S_SCAN  = 7'b0001000,
    S_WPREP = 7'b0010000,
    S_WRITE = 7'b0100000,
    S_PUT   = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_stall = state != S_IDLE;

  // sequencing of one item
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.take   = 1'b1;
          state_next = S_SETUP;
        end
      end
      S_SETUP: begin
        cmd.prep = 1'b1;
        if (stat.is_free) begin
          state_next = stat.free_go ? S_WRITE : S_PUT;
        end else begin
          state_next = stat.alloc_ok ? S_SCAN : S_PUT;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.hit) begin
          state_next = S_WPREP;
        end else if (stat.scan_last) begin
          state_next = S_PUT;
        end
      end
      S_WPREP: begin
        cmd.wprep  = 1'b1;
        state_next = S_WRITE;
      end
      S_WRITE: begin
        cmd.write = 1'b1;
        if (stat.write_last) begin
          state_next = S_PUT;
        end
      end
      S_PUT: begin
        if (stat.out_free) begin
          cmd.put    = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

// File: src/first_fit_block_allocator_top.sv
`timescale 1ns / 1ps
`default_nettype none
// First-fit allocator over a map of rows x cols blocks, read as one line.
// Input channel (in_valid / in_stall) carries an allocate or free item;
// output channel (out_valid / out_stall) returns one status item per input.
// The map sits in a RAM of 8 blocks per word; one word is scanned or
// rewritten per cycle, so the word count of the map sets the latency.
// Allocate: a setup step, then scan steps up to the word where the run
// ends, then a seek step and a write per word the run covers, then a
// step to load the result. Free: a setup step, a write per word of the
// clipped range, a result step. Size 0 or an allocate larger than the map
// takes setup and result only. One item is worked at a time; in_stall is
// low only while the block is idle.
// Reset sets rows/cols to 16/64 and starts a clearing pass over the 128
// map words that marks every block free; in_stall stays high during it,
// while config writes (cfg_write, cfg_index, cfg_data) are taken at any time.
// A result waits in the output register while out_stall is high; the next
// item may be accepted meanwhile and holds in its last cycle until the
// register frees.
module first_fit_block_allocator_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [ffba_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ffba_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [ffba_pkg::OP_W-1:0]       operation,
  input  logic [ffba_pkg::SIZE_W-1:0]     request_size,
  input  logic [ffba_pkg::OWN_W-1:0]      owner_id,
  input  logic [ffba_pkg::BLK_W-1:0]      free_start,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [ffba_pkg::ST_W-1:0]       status,
  output logic [ffba_pkg::BLK_W-1:0]      allocated_start
);
  import ffba_pkg::*;

  ffba_cmd_t  cmd;
  ffba_stat_t stat;

  // sequencer
  ffba_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .cmd     (cmd),
    .stat    (stat)
  );

  // map, registers and result
  ffba_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .operation      (operation),
    .request_size   (request_size),
    .owner_id       (owner_id),
    .free_start     (free_start),
    .cmd            (cmd),
    .stat           (stat),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .status         (status),
    .allocated_start(allocated_start)
  );

endmodule
`default_nettype wire
